/* hw/rtl/cdc_pkg.sv */
// Shared constants and types for the 3x3 convolution, divide and clamp block.
// No dependencies; used by every module under hw/rtl except cdc_ram.
package cdc_pkg;

  localparam int MAX_WIDTH_DEF = 1024;
  localparam int COEF_BITS_DEF = 8;
  localparam int PIX_BITS = 8;
  localparam int DIV_BITS = 10;
  localparam int WIDTH_BITS = 11;
  localparam int HEIGHT_BITS = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int PIX_MAX = 255;
  localparam int CFG_IDX_BITS = 3;

  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_TOP = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_MID = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_COEF_BOT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_DIVISOR = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 3'd5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the input sample, start the line store read
    logic shift;     // shift the window with the read data, write the stores
    logic mac_clear; // clear the accumulator before the products
    logic mac_step;  // add one window row of products
    logic div_start; // load the divider
    logic div_step;  // one restoring division step
    logic out_load;  // place the clamped quotient into the output register
  } cdc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic interior;  // the sample just shifted in completes an interior pixel
  } cdc_stat_t;

endpackage

/* hw/rtl/cdc_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module cdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

/* hw/rtl/cdc_datapath.sv */
// Datapath: position counters, line stores, window, multiply-accumulate,
// serial divider and clamp. Depends on cdc_pkg and cdc_ram.
module cdc_datapath #(
  parameter int MAX_WIDTH = cdc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = cdc_pkg::COEF_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cdc_pkg::cdc_cmd_t                 cmd,
  output cdc_pkg::cdc_stat_t                stat,
  input  logic [cdc_pkg::PIX_BITS-1:0]      pixel_in,
  input  logic [3*COEF_BITS-1:0]            coef_top,
  input  logic [3*COEF_BITS-1:0]            coef_mid,
  input  logic [3*COEF_BITS-1:0]            coef_bot,
  input  logic [cdc_pkg::DIV_BITS-1:0]      divisor,
  input  logic [cdc_pkg::WIDTH_BITS-1:0]    image_width,
  input  logic [cdc_pkg::HEIGHT_BITS-1:0]   image_height,
  output logic [cdc_pkg::PIX_BITS-1:0]      filtered_pixel,
  output logic                              frame_last
);

  localparam int PB = cdc_pkg::PIX_BITS;
  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = cdc_pkg::HEIGHT_BITS;
  // Product of an 8-bit sample and a coefficient, nine of them summed.
  localparam int PW = PB + 1 + COEF_BITS;
  localparam int SW = PW + 4;
  localparam int DB = cdc_pkg::DIV_BITS;
  localparam int EW = (cdc_pkg::WIDTH_BITS > CW) ? cdc_pkg::WIDTH_BITS : CW;

  // Effective geometry.
  logic [EW-1:0] w_eff;
  logic [HW-1:0] h_eff;
  always_comb begin
    if (EW'(image_width) < EW'(3)) begin
      w_eff = EW'(3);
    end else if (EW'(image_width) > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = EW'(image_width);
    end
    if (image_height < HW'(3)) begin
      h_eff = HW'(3);
    end else if (image_height > HW'(cdc_pkg::MAX_HEIGHT)) begin
      h_eff = HW'(cdc_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
  end

  logic [CW-1:0] col_count;
  logic [HW-1:0] row_count;
  logic [PB-1:0] pix;
  logic [PB-1:0] above, above2;
  logic [PB-1:0] win [3][3];
  logic          interior;
  logic          last_pos;

  // Line stores are addressed by the column of the sample being taken.
  cdc_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_store_a (
    .clk   (clk),
    .we    (cmd.shift),
    .addr  (col_count[AW-1:0]),
    .wdata (pix),
    .rdata (above)
  );

  cdc_ram #(.WIDTH(PB), .DEPTH(MAX_WIDTH)) u_store_b (
    .clk   (clk),
    .we    (cmd.shift),
    .addr  (col_count[AW-1:0]),
    .wdata (above),
    .rdata (above2)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pix <= pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      interior  <= 1'b0;
      last_pos  <= 1'b0;
    end else if (cmd.shift) begin
      interior <= (EW'(col_count) >= EW'(2)) && (row_count >= HW'(2)) &&
                  (EW'(col_count) < w_eff) && (row_count < h_eff);
      last_pos <= (EW'(col_count) == w_eff - EW'(1)) && (row_count == h_eff - HW'(1));
      if (EW'(col_count) + EW'(1) >= w_eff) begin
        col_count <= '0;
        row_count <= (row_count + HW'(1) >= h_eff) ? '0 : row_count + HW'(1);
      end else begin
        col_count <= col_count + CW'(1);
      end
    end
  end

  assign stat.interior = interior;

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= above2;
      win[1][2] <= above;
      win[2][2] <= pix;
    end
  end

  // One window row per step: three products added to the sum.
  logic [1:0]                  mac_row;
  logic signed [SW-1:0]        acc;
  logic [3*COEF_BITS-1:0]      row_coef;
  logic signed [SW-1:0]        row_sum;
  always_comb begin
    case (mac_row)
      2'd0:    row_coef = coef_top;
      2'd1:    row_coef = coef_mid;
      default: row_coef = coef_bot;
    endcase
    row_sum = '0;
    for (int k = 0; k < 3; k++) begin
      row_sum = row_sum + SW'($signed({1'b0, win[mac_row][k]}) *
                              $signed(row_coef[k*COEF_BITS +: COEF_BITS]));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mac_clear) begin
      acc     <= '0;
      mac_row <= '0;
    end else if (cmd.mac_step) begin
      acc     <= acc + row_sum;
      mac_row <= mac_row + 2'd1;
    end
  end

  // Restoring division of the magnitude, one quotient bit a step.
  logic [SW-1:0] dvd;
  logic [DB-1:0] rem;
  logic          neg;
  logic [DB-1:0] dsr;
  logic [DB:0]   trial;
  assign trial = {rem, dvd[SW-1]} - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      neg <= acc[SW-1];
      dvd <= acc[SW-1] ? SW'(-acc) : SW'(acc);
      rem <= '0;
      dsr <= (divisor == '0) ? DB'(1) : divisor;
    end else if (cmd.div_step) begin
      if (!trial[DB]) begin
        rem <= trial[DB-1:0];
        dvd <= {dvd[SW-2:0], 1'b1};
      end else begin
        rem <= {rem[DB-2:0], dvd[SW-1]};
        dvd <= {dvd[SW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (neg || dvd == '0) begin
        filtered_pixel <= '0;
      end else if (dvd > SW'(cdc_pkg::PIX_MAX)) begin
        filtered_pixel <= PB'(cdc_pkg::PIX_MAX);
      end else begin
        filtered_pixel <= dvd[PB-1:0];
      end
      frame_last <= last_pos;
    end
  end

endmodule

/* hw/rtl/cdc_ctrl.sv */
// Controller state machine: handshakes and sequencing of the datapath.
// Depends on cdc_pkg.
module cdc_ctrl #(
  parameter int COEF_BITS = cdc_pkg::COEF_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output cdc_pkg::cdc_cmd_t  cmd,
  input  cdc_pkg::cdc_stat_t stat
);

  localparam int SW = cdc_pkg::PIX_BITS + 1 + COEF_BITS + 4;
  localparam int SCW = $clog2(SW + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_READ  = 3'd1;
  localparam logic [2:0] ST_SHIFT = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MAC   = 3'd4;
  localparam logic [2:0] ST_DIV   = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]     state, state_next;
  logic [SCW-1:0] step, step_next;
  logic           out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && out_stall;
    cmd            = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (stat.interior) begin
          cmd.mac_clear = 1'b1;
          step_next     = '0;
          state_next    = ST_MAC;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_MAC: begin
        cmd.mac_step = 1'b1;
        step_next    = step + SCW'(1);
        if (step == SCW'(2)) begin
          state_next = ST_DIV;
          step_next  = '0;
        end
      end
      ST_DIV: begin
        if (step == '0) begin
          cmd.div_start = 1'b1;
        end else begin
          cmd.div_step = 1'b1;
        end
        step_next = step + SCW'(1);
        if (step == SCW'(SW)) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid || !out_stall) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* hw/rtl/conv3x3_divide_clamp.sv */
// Top level of the 3x3 convolution filter with divide and clamp.
// Depends on cdc_pkg, cdc_ctrl, cdc_datapath and cdc_ram.
//
// The block takes 8-bit samples of one color plane in raster order and, for
// every interior pixel, forms the weighted sum of its 3x3 neighborhood with
// signed coefficients, divides it by the divisor (truncating toward zero),
// clamps it to 0..255 and sends it out with a mark on the frame's last
// interior pixel. Border samples produce no output transaction. Each input
// transaction goes through the line store read, window shift and interior
// check, the input stalled until it is done; one that makes a result then
// takes three multiply-accumulate steps over the window rows and the serial
// divider, one quotient bit a cycle over the sum width (21 bits with 8-bit
// coefficients). A finished result waits in the output register while the
// next sample is taken; a new result that finds the previous one stalled
// waits in the last step until the output moves. Configuration must be
// written only while the block is idle; the block does not enforce it.
module conv3x3_divide_clamp #(
  parameter int MAX_WIDTH = cdc_pkg::MAX_WIDTH_DEF,
  parameter int COEF_BITS = cdc_pkg::COEF_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [cdc_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [((3*COEF_BITS > cdc_pkg::HEIGHT_BITS) ?
                 3*COEF_BITS : cdc_pkg::HEIGHT_BITS)-1:0] cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [cdc_pkg::PIX_BITS-1:0]         pixel_in,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [cdc_pkg::PIX_BITS-1:0]         filtered_pixel,
  output logic                                 frame_last
);

  localparam int CB = 3 * COEF_BITS;

  logic [CB-1:0]                       coef_top, coef_mid, coef_bot;
  logic [cdc_pkg::DIV_BITS-1:0]        divisor;
  logic [cdc_pkg::WIDTH_BITS-1:0]      image_width;
  logic [cdc_pkg::HEIGHT_BITS-1:0]     image_height;

  // Register file; the data port is as wide as the widest register, the
  // narrower registers take its low bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      coef_top     <= '0;
      coef_mid     <= CB'(65536);
      coef_bot     <= '0;
      divisor      <= cdc_pkg::DIV_BITS'(1);
      image_width  <= cdc_pkg::WIDTH_BITS'(1024);
      image_height <= cdc_pkg::HEIGHT_BITS'(1024);
    end else if (cfg_we) begin
      case (cfg_index)
        cdc_pkg::REG_COEF_TOP: coef_top <= cfg_data[CB-1:0];
        cdc_pkg::REG_COEF_MID: coef_mid <= cfg_data[CB-1:0];
        cdc_pkg::REG_COEF_BOT: coef_bot <= cfg_data[CB-1:0];
        cdc_pkg::REG_DIVISOR:  divisor <= cfg_data[cdc_pkg::DIV_BITS-1:0];
        cdc_pkg::REG_WIDTH:    image_width <= cfg_data[cdc_pkg::WIDTH_BITS-1:0];
        cdc_pkg::REG_HEIGHT:   image_height <= cfg_data[cdc_pkg::HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  cdc_pkg::cdc_cmd_t  cmd;
  cdc_pkg::cdc_stat_t stat;

  cdc_ctrl #(.COEF_BITS(COEF_BITS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  cdc_datapath #(.MAX_WIDTH(MAX_WIDTH), .COEF_BITS(COEF_BITS)) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .pixel_in       (pixel_in),
    .coef_top       (coef_top),
    .coef_mid       (coef_mid),
    .coef_bot       (coef_bot),
    .divisor        (divisor),
    .image_width    (image_width),
    .image_height   (image_height),
    .filtered_pixel (filtered_pixel),
    .frame_last     (frame_last)
  );

endmodule
